/* hdl/lfrl_pkg.sv */
// shared types and constants of the login failure rate limiter
`timescale 1ns / 1ps
`default_nettype none

package lfrl_pkg;

	// result status codes
	localparam logic [1:0] ST_GRANTED = 2'd0;
	localparam logic [1:0] ST_FAILED  = 2'd1;
	localparam logic [1:0] ST_LIMITED = 2'd2;
	localparam logic [1:0] ST_QUERY   = 2'd3;

	// function codes of an input item
	localparam logic FUNC_LOGIN = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// configuration register indexes
	localparam logic CFG_FAILURE_LIMIT  = 1'b0;
	localparam logic CFG_WINDOW_SECONDS = 1'b1;

	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0]  RESET_FAILURE_LIMIT  = 8'd5;
	localparam logic [15:0] RESET_WINDOW_SECONDS = 16'd60;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic        func;
		logic [31:0] client;
		logic [31:0] now_seconds;
		logic        auth_ok;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] retry_secs;
		logic [7:0]  failures_now;
	} out_t;

	typedef enum logic [1:0] {
		RES_QUERY,
		RES_LIMIT,
		RES_GRANT,
		RES_FAIL
	} res_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      cap_in;
		logic      fetch;
		logic      delta;
		logic      wipe;
		logic      bump;
		logic      res_set;
		res_kind_t res_kind;
		logic      alloc_free;
		logic      scan_init;
		logic      scan_step;
		logic      victim_write;
		logic      load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic query;
		logic hit;
		logic limited;
		logic expired;
		logic auth_ok;
		logic free_any;
		logic scan_last;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

/* hdl/lfrl_dp.sv */
// datapath of the rate limiter: client table, time arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none

module lfrl_dp #(
	parameter int unsigned TRACKED_CLIENTS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lfrl_pkg::in_t                 in_data,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [lfrl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire lfrl_pkg::cmd_t                cmd,
	output lfrl_pkg::sts_t                     sts,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output lfrl_pkg::out_t                     out_data
);

	localparam int unsigned IDX_W = (TRACKED_CLIENTS > 1) ? $clog2(TRACKED_CLIENTS) : 1;

	logic [31:0] client_q [TRACKED_CLIENTS];
	logic [7:0]  count_q  [TRACKED_CLIENTS];
	logic [31:0] time_q   [TRACKED_CLIENTS];

	logic [7:0]  limit_q;
	logic [15:0] window_q;

	logic        func_q;
	logic [31:0] who_q;
	logic [31:0] now_q;
	logic        ok_q;

	logic             hit_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       cnt_q;
	logic [31:0]      tim_q;
	logic [33:0]      delta_q;

	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] old_idx_q;
	logic [31:0]      old_time_q;

	logic [1:0]  res_status_q;
	logic [15:0] res_retry_q;
	logic [7:0]  res_fail_q;

	logic          out_valid_q;
	lfrl_pkg::out_t out_q;

	logic [TRACKED_CLIENTS-1:0] match_vec;
	logic [TRACKED_CLIENTS-1:0] free_vec;
	logic [IDX_W-1:0]           match_idx;
	logic [IDX_W-1:0]           free_idx;

	logic        limited;
	logic        expired;
	logic [33:0] retry_full;
	logic [15:0] retry_val;
	logic [7:0]  bump_cnt;
	logic [7:0]  new_cnt;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       wr_cnt;
	logic             wr_fresh;

	// per entry compare and free flags, then lowest index wins
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = 0; i < TRACKED_CLIENTS; i++) begin
			match_vec[i] = (count_q[i] != 8'd0) && (client_q[i] == who_q);
			free_vec[i]  = (count_q[i] == 8'd0);
		end
		for (int i = TRACKED_CLIENTS - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				match_idx = IDX_W'(i);
			end
			if (free_vec[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// delta_q is a signed 34-bit difference, the window is zero-extended and never negative
	always_comb begin
		expired    = $signed(delta_q) >= $signed({18'd0, window_q});
		limited    = hit_q && (cnt_q >= limit_q) && !expired;
		retry_full = {18'd0, window_q} - delta_q;
		if (!limited) begin
			retry_val = 16'd0;
		end else if (|retry_full[33:16]) begin
			retry_val = 16'hFFFF;
		end else begin
			retry_val = retry_full[15:0];
		end
		bump_cnt = (cnt_q == lfrl_pkg::COUNT_MAX) ? lfrl_pkg::COUNT_MAX : cnt_q + 8'd1;
		new_cnt  = cmd.bump ? bump_cnt : 8'd1;
	end

	always_comb begin
		sts.query     = (func_q == lfrl_pkg::FUNC_QUERY);
		sts.hit       = hit_q;
		sts.limited   = limited;
		sts.expired   = expired;
		sts.auth_ok   = ok_q;
		sts.free_any  = |free_vec;
		sts.scan_last = (scan_q == IDX_W'(TRACKED_CLIENTS - 1));
		sts.out_busy  = out_valid_q && out_stall;
	end

	// one table write port
	always_comb begin
		wr_en    = 1'b0;
		wr_idx   = idx_q;
		wr_cnt   = 8'd0;
		wr_fresh = 1'b0;
		if (cmd.wipe) begin
			wr_en = 1'b1;
		end else if (cmd.bump) begin
			wr_en  = 1'b1;
			wr_cnt = bump_cnt;
		end else if (cmd.alloc_free) begin
			wr_en    = 1'b1;
			wr_idx   = free_idx;
			wr_cnt   = 8'd1;
			wr_fresh = 1'b1;
		end else if (cmd.victim_write) begin
			wr_en    = 1'b1;
			wr_idx   = old_idx_q;
			wr_cnt   = 8'd1;
			wr_fresh = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACKED_CLIENTS; i++) begin
				count_q[i] <= 8'd0;
			end
		end else if (wr_en) begin
			count_q[wr_idx] <= wr_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !cmd.wipe) begin
			time_q[wr_idx] <= now_q;
			if (wr_fresh) begin
				client_q[wr_idx] <= who_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= lfrl_pkg::RESET_FAILURE_LIMIT;
			window_q <= lfrl_pkg::RESET_WINDOW_SECONDS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfrl_pkg::CFG_FAILURE_LIMIT: begin
					limit_q <= cfg_data[7:0];
				end
				lfrl_pkg::CFG_WINDOW_SECONDS: begin
					window_q <= cfg_data;
				end
				default: begin
					limit_q <= limit_q;
				end
			endcase
		end
	end

	// item fields and working values
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			func_q <= in_data.func;
			who_q  <= in_data.client;
			now_q  <= in_data.now_seconds;
			ok_q   <= in_data.auth_ok;
		end
		if (cmd.fetch) begin
			hit_q <= |match_vec;
			idx_q <= match_idx;
			cnt_q <= (|match_vec) ? count_q[match_idx] : 8'd0;
			tim_q <= time_q[match_idx];
		end
		if (cmd.delta) begin
			delta_q <= {2'b00, now_q} - {2'b00, tim_q};
		end
		// oldest entry search, strict compare keeps the lowest index on a tie
		if (cmd.scan_init) begin
			scan_q     <= '0;
			old_idx_q  <= '0;
			old_time_q <= '1;
		end else if (cmd.scan_step) begin
			if (time_q[scan_q] < old_time_q) begin
				old_idx_q  <= scan_q;
				old_time_q <= time_q[scan_q];
			end
			scan_q <= scan_q + IDX_W'(1);
		end
		if (cmd.res_set) begin
			case (cmd.res_kind)
				lfrl_pkg::RES_QUERY: begin
					res_status_q <= lfrl_pkg::ST_QUERY;
					res_retry_q  <= retry_val;
					res_fail_q   <= cnt_q;
				end
				lfrl_pkg::RES_LIMIT: begin
					res_status_q <= lfrl_pkg::ST_LIMITED;
					res_retry_q  <= retry_val;
					res_fail_q   <= cnt_q;
				end
				lfrl_pkg::RES_GRANT: begin
					res_status_q <= lfrl_pkg::ST_GRANTED;
					res_retry_q  <= 16'd0;
					res_fail_q   <= 8'd0;
				end
				default: begin
					res_status_q <= lfrl_pkg::ST_FAILED;
					res_retry_q  <= 16'd0;
					res_fail_q   <= new_cnt;
				end
			endcase
		end
		if (cmd.load_out) begin
			out_q.status       <= res_status_q;
			out_q.retry_secs   <= res_retry_q;
			out_q.failures_now <= res_fail_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_victim_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.victim_write |-> !(|free_vec))
		else $error("victim entry replaced while a free entry exists");

	a_single_live_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch |-> $onehot0(match_vec))
		else $error("client holds more than one live entry");

	a_failed_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == lfrl_pkg::ST_FAILED) |-> out_q.failures_now != 8'd0)
		else $error("failed login reported with zero failures");

	a_limited_has_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == lfrl_pkg::ST_LIMITED) |-> out_q.retry_secs != 16'd0)
		else $error("rate limited result without retry time");
`endif

endmodule

`default_nettype wire

/* hdl/lfrl_ctrl.sv */
// controller state machine of the rate limiter
`timescale 1ns / 1ps
`default_nettype none

module lfrl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire lfrl_pkg::sts_t sts,
	output lfrl_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_DELTA,
		S_DECIDE,
		S_ALLOC,
		S_SCAN,
		S_VICTIM,
		S_RESP
	} state_t;

	state_t state_q;

	always_comb begin
		cmd          = '0;
		cmd.res_kind = lfrl_pkg::RES_FAIL;
		unique case (state_q)
			S_IDLE: begin
				cmd.cap_in = in_valid && !in_stall;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
			end
			S_DELTA: begin
				cmd.delta = 1'b1;
			end
			S_DECIDE: begin
				if (sts.query) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = lfrl_pkg::RES_QUERY;
				end else if (sts.limited) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = lfrl_pkg::RES_LIMIT;
				end else if (sts.auth_ok) begin
					// success clears the entry whether or not it ran out
					cmd.wipe     = sts.hit;
					cmd.res_set  = 1'b1;
					cmd.res_kind = lfrl_pkg::RES_GRANT;
				end else if (sts.hit && !sts.expired) begin
					cmd.bump     = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_kind = lfrl_pkg::RES_FAIL;
				end else begin
					cmd.wipe = sts.hit;
				end
			end
			S_ALLOC: begin
				if (sts.free_any) begin
					cmd.alloc_free = 1'b1;
					cmd.res_set    = 1'b1;
					cmd.res_kind   = lfrl_pkg::RES_FAIL;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_VICTIM: begin
				cmd.victim_write = 1'b1;
				cmd.res_set      = 1'b1;
				cmd.res_kind     = lfrl_pkg::RES_FAIL;
			end
			S_RESP: begin
				cmd.load_out = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_stall <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					in_stall <= 1'b0;
					if (in_valid && !in_stall) begin
						state_q  <= S_FETCH;
						in_stall <= 1'b1;
					end
				end
				S_FETCH: begin
					state_q <= S_DELTA;
				end
				S_DELTA: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (sts.query || sts.limited || sts.auth_ok ||
						(sts.hit && !sts.expired)) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					state_q <= sts.free_any ? S_RESP : S_SCAN;
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_VICTIM;
					end
				end
				S_VICTIM: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!sts.out_busy) begin
						state_q  <= S_IDLE;
						in_stall <= 1'b0;
					end
				end
				default: begin
					state_q  <= S_IDLE;
					in_stall <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/login_failure_rate_limiter.sv */
// top level of the per-client login failure rate limiter
// An item is either a login attempt or a retry-after query for one client, and
// each item gives exactly one result. The block handles one item at a time:
// after acceptance it goes through table lookup, elapsed time, decision and
// result load, with an allocation step added when a failure needs a new entry,
// and when the table is full a search for the oldest entry, which reads one
// entry per cycle, followed by the replacement of that entry.
// in_stall is high from acceptance until the result is loaded into the output
// register; a result waiting downstream holds the block only when the next
// result is ready. Configuration writes belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module login_failure_rate_limiter #(
	parameter int unsigned TRACKED_CLIENTS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire lfrl_pkg::in_t                 in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output lfrl_pkg::out_t                     out_data,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [lfrl_pkg::CFG_DATA_W-1:0] cfg_data
);

	lfrl_pkg::cmd_t cmd;
	lfrl_pkg::sts_t sts;

	lfrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfrl_dp #(
		.TRACKED_CLIENTS (TRACKED_CLIENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* verif/tb_login_failure_rate_limiter.sv */
// self-checking testbench of the login failure rate limiter
`timescale 1ns / 1ps

module tb_login_failure_rate_limiter;

	localparam int TABLE_DEPTH     = 8;
	localparam int QUIET_GAP       = 4;
	localparam int TAIL_CYCLES     = 40;
	localparam int WATCHDOG_CYCLES = 5000;
	localparam int PHASE_COUNT     = 7;
	localparam int PHASE_ITEMS     = 220;
	localparam int MAX_REPORTS     = 10;

	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_CFG,
		STEP_MODE
	} step_kind_t;

	typedef struct {
		step_kind_t      kind;
		lfrl_pkg::in_t   item;
		logic            cfg_idx;
		logic [15:0]     cfg_val;
		int              idle_pct;
		int              stall_pct;
	} stim_step_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	lfrl_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	lfrl_pkg::out_t out_data;
	logic           cfg_we = 1'b0;
	logic           cfg_index = lfrl_pkg::CFG_FAILURE_LIMIT;
	logic [15:0]    cfg_data = '0;

	// predictor copy of the client table and the registers
	logic [31:0] trk_client [TABLE_DEPTH];
	logic [7:0]  trk_count  [TABLE_DEPTH];
	logic [31:0] trk_stamp  [TABLE_DEPTH];
	logic [7:0]  lim_cfg;
	logic [15:0] win_cfg;

	stim_step_t     stim_q [$];
	lfrl_pkg::out_t want_q [$];

	bit          in_accepted = 1'b0;
	int          quiet_cnt = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          mism_cnt = 0;
	int          stuck_cycles = 0;

	logic [31:0] t_now = '0;
	logic [31:0] client_pool [12];

	int phase_lim [PHASE_COUNT] = '{5, 1, 0, 3, 255, 2, 8};
	int phase_win [PHASE_COUNT] = '{60, 1, 0, 10, 65535, 65535, 300};
	int mode_idle  [4] = '{0, 53, 0, 14};
	int mode_stall [4] = '{0, 0, 53, 14};

	login_failure_rate_limiter #(
		.TRACKED_CLIENTS(TABLE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int find_live(logic [31:0] who);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (trk_count[i] != 8'd0 && trk_client[i] == who)
				return i;
		end
		return TABLE_DEPTH;
	endfunction

	function automatic void clear_entry(int i);
		trk_client[i] = '0;
		trk_count[i]  = '0;
		trk_stamp[i]  = '0;
	endfunction

	// signed seconds since the entry's last failure, no wrap
	function automatic longint age(int i, logic [31:0] now);
		longint a;
		longint b;
		a = now;
		b = trk_stamp[i];
		return a - b;
	endfunction

	function automatic logic [15:0] hold_time(int i, logic [31:0] now);
		longint d;
		longint w;
		longint r;
		d = age(i, now);
		w = win_cfg;
		if (trk_count[i] < lim_cfg || d >= w)
			return 16'd0;
		r = w - d;
		if (r > 65535)
			r = 65535;
		return r[15:0];
	endfunction

	// works out the result of one item and updates the table copy
	function automatic lfrl_pkg::out_t predict_attempt(lfrl_pkg::in_t it);
		lfrl_pkg::out_t r;
		int             hit;
		int             slot;
		longint         d;
		longint         w;
		r = '0;
		w = win_cfg;
		hit = find_live(it.client);
		if (it.func == lfrl_pkg::FUNC_QUERY) begin
			r.status = lfrl_pkg::ST_QUERY;
			if (hit < TABLE_DEPTH) begin
				r.retry_secs   = hold_time(hit, it.now_seconds);
				r.failures_now = trk_count[hit];
			end
			return r;
		end
		if (hit < TABLE_DEPTH) begin
			d = age(hit, it.now_seconds);
			if (trk_count[hit] >= lim_cfg && d < w) begin
				r.status       = lfrl_pkg::ST_LIMITED;
				r.retry_secs   = hold_time(hit, it.now_seconds);
				r.failures_now = trk_count[hit];
				return r;
			end
			if (d >= w)
				clear_entry(hit);
		end
		if (it.auth_ok) begin
			hit = find_live(it.client);
			if (hit < TABLE_DEPTH)
				clear_entry(hit);
			r.status = lfrl_pkg::ST_GRANTED;
			return r;
		end
		slot = find_live(it.client);
		if (slot == TABLE_DEPTH) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (slot == TABLE_DEPTH && trk_count[i] == 8'd0)
					slot = i;
			end
			if (slot == TABLE_DEPTH) begin
				// table full: reuse the oldest stamp, lowest index on a tie
				slot = 0;
				for (int i = 1; i < TABLE_DEPTH; i++) begin
					if (trk_stamp[i] < trk_stamp[slot])
						slot = i;
				end
				clear_entry(slot);
			end
		end
		trk_client[slot] = it.client;
		if (trk_count[slot] != lfrl_pkg::COUNT_MAX)
			trk_count[slot] = trk_count[slot] + 8'd1;
		trk_stamp[slot] = it.now_seconds;
		r.status       = lfrl_pkg::ST_FAILED;
		r.failures_now = trk_count[slot];
		return r;
	endfunction

	function automatic stim_step_t blank_step(step_kind_t kind);
		stim_step_t s;
		s.kind      = kind;
		s.item      = '0;
		s.cfg_idx   = 1'b0;
		s.cfg_val   = '0;
		s.idle_pct  = 0;
		s.stall_pct = 0;
		return s;
	endfunction

	task automatic push_item(logic fn, logic [31:0] who, logic [31:0] now, logic ok);
		stim_step_t s;
		s = blank_step(STEP_ITEM);
		s.item.func        = fn;
		s.item.client      = who;
		s.item.now_seconds = now;
		s.item.auth_ok     = ok;
		stim_q.insert(stim_q.size(), s);
	endtask

	task automatic push_cfg(logic idx, logic [15:0] val);
		stim_step_t s;
		s = blank_step(STEP_CFG);
		s.cfg_idx = idx;
		s.cfg_val = val;
		stim_q.insert(stim_q.size(), s);
	endtask

	task automatic push_mode(int idle, int stall);
		stim_step_t s;
		s = blank_step(STEP_MODE);
		s.idle_pct  = idle;
		s.stall_pct = stall;
		stim_q.insert(stim_q.size(), s);
	endtask

	// mostly failure bursts per client followed by a query and sometimes a successful retry, the rest noise
	task automatic gen_phase(int n, logic [15:0] win);
		int          queued;
		int          len;
		int          pick;
		logic [31:0] who;
		queued = 0;
		while (queued < n) begin
			who = client_pool[$urandom_range(11)];
			if ($urandom_range(5) != 0) begin
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					push_item(lfrl_pkg::FUNC_LOGIN, who, t_now, 1'b0);
					t_now = t_now + $urandom_range(0, 2);
				end
				push_item(lfrl_pkg::FUNC_QUERY, who, t_now, 1'($urandom_range(1)));
				queued = queued + len + 1;
				if ($urandom_range(1)) begin
					push_item(lfrl_pkg::FUNC_LOGIN, who, t_now, 1'b1);
					queued++;
				end
			end else begin
				pick = $urandom_range(99);
				if (pick < 12)
					t_now = t_now + 32'(win) + $urandom_range(0, 3);
				else if (pick < 18)
					t_now = t_now - $urandom_range(1, 1000);
				else if (pick < 22)
					t_now = $urandom;
				else
					t_now = t_now + $urandom_range(0, 5);
				if ($urandom_range(9) == 0)
					who = $urandom;
				push_item(1'($urandom_range(1)), who, t_now, 1'($urandom_range(1)));
				queued++;
			end
		end
	endtask

	// driver: one item, register write or mode change per free slot
	always @(negedge clk) begin : drive_step
		logic          nv;
		lfrl_pkg::in_t nd;
		logic          nwe;
		logic          nidx;
		logic [15:0]   ndat;
		nv   = in_valid;
		nd   = in_data;
		nwe  = 1'b0;
		nidx = cfg_index;
		ndat = cfg_data;
		if (arst_n && !(in_valid && !in_accepted)) begin
			nv = 1'b0;
			if (stim_q.size() > 0) begin
				case (stim_q[0].kind)
					STEP_MODE: begin
						idle_pct  = stim_q[0].idle_pct;
						stall_pct = stim_q[0].stall_pct;
						void'(stim_q.pop_front());
					end
					STEP_CFG: begin
						if (quiet_cnt >= QUIET_GAP) begin
							nwe  = 1'b1;
							nidx = stim_q[0].cfg_idx;
							ndat = stim_q[0].cfg_val;
							void'(stim_q.pop_front());
						end
					end
					default: begin
						if ($urandom_range(99) >= idle_pct) begin
							nv = 1'b1;
							nd = stim_q[0].item;
							void'(stim_q.pop_front());
						end
					end
				endcase
			end
		end
		in_valid  <= nv;
		in_data   <= nd;
		cfg_we    <= nwe;
		cfg_index <= nidx;
		cfg_data  <= ndat;
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// monitor: predicts on input handshakes and checks output handshakes
	always @(posedge clk) begin : watch_ports
		lfrl_pkg::out_t w;
		in_accepted = in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == lfrl_pkg::CFG_FAILURE_LIMIT)
					lim_cfg = cfg_data[7:0];
				else
					win_cfg = cfg_data;
			end
			if (in_valid && !in_stall)
				want_q.insert(want_q.size(), predict_attempt(in_data));
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					if (mism_cnt < MAX_REPORTS)
						$display("unexpected result: status %0d retry %0d failures %0d",
							out_data.status, out_data.retry_secs, out_data.failures_now);
					mism_cnt++;
				end else begin
					w = want_q.pop_front();
					if (out_data.status !== w.status ||
						out_data.retry_secs !== w.retry_secs ||
						out_data.failures_now !== w.failures_now) begin
						if (mism_cnt < MAX_REPORTS)
							$display({"mismatch: expected status %0d retry %0d failures %0d,",
								" got status %0d retry %0d failures %0d"},
								w.status, w.retry_secs, w.failures_now,
								out_data.status, out_data.retry_secs, out_data.failures_now);
						mism_cnt++;
					end
				end
			end
			if (want_q.size() == 0 && !in_valid && !cfg_we && !out_valid)
				quiet_cnt++;
			else
				quiet_cnt = 0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			trk_client[i] = '0;
			trk_count[i]  = '0;
			trk_stamp[i]  = '0;
		end
		lim_cfg = lfrl_pkg::RESET_FAILURE_LIMIT;
		win_cfg = lfrl_pkg::RESET_WINDOW_SECONDS;
		client_pool[0] = 32'h0000_0000;
		client_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 12; i++)
			client_pool[i] = $urandom;

		// directed part at the reset settings
		push_mode(0, 0);
		push_item(lfrl_pkg::FUNC_QUERY, 32'h0, 32'h0, 1'b0);
		push_item(lfrl_pkg::FUNC_LOGIN, 32'h0, 32'h0, 1'b1);
		for (int k = 0; k < 5; k++)
			push_item(lfrl_pkg::FUNC_LOGIN, 32'hFFFF_FFFF, 32'd100 + k, 1'b0);
		push_item(lfrl_pkg::FUNC_LOGIN, 32'hFFFF_FFFF, 32'd105, 1'b1);
		push_item(lfrl_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 32'd105, 1'b0);
		// time going backwards
		push_item(lfrl_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 32'd50, 1'b1);
		// window run out, then a fresh count
		push_item(lfrl_pkg::FUNC_LOGIN, 32'hFFFF_FFFF, 32'd164, 1'b0);
		push_item(lfrl_pkg::FUNC_LOGIN, 32'hFFFF_FFFF, 32'd165, 1'b1);
		push_item(lfrl_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 32'd165, 1'b0);
		// far backwards gives a saturated retry-after
		for (int k = 0; k < 5; k++)
			push_item(lfrl_pkg::FUNC_LOGIN, 32'h1, 32'hFFFF_FFF0 + k, 1'b0);
		push_item(lfrl_pkg::FUNC_QUERY, 32'h1, 32'h0, 1'b0);
		// fill the table, then force reuse of the oldest entry
		for (int k = 0; k < 7; k++)
			push_item(lfrl_pkg::FUNC_LOGIN, 32'h100 + k, 32'd200 + k, 1'b0);
		push_item(lfrl_pkg::FUNC_LOGIN, 32'h8000_0000, 32'd300, 1'b0);
		push_item(lfrl_pkg::FUNC_QUERY, 32'h100, 32'd300, 1'b0);
		t_now = 32'd400;

		for (int p = 0; p < PHASE_COUNT; p++) begin
			push_cfg(lfrl_pkg::CFG_FAILURE_LIMIT,
				{8'($urandom_range(255)), 8'(phase_lim[p])});
			push_cfg(lfrl_pkg::CFG_WINDOW_SECONDS, 16'(phase_win[p]));
			push_mode(mode_idle[p % 4], mode_stall[p % 4]);
			gen_phase(PHASE_ITEMS, 16'(phase_win[p]));
		end

		// one client driven all the way to a count of 255
		push_cfg(lfrl_pkg::CFG_FAILURE_LIMIT, 16'h00FF);
		push_cfg(lfrl_pkg::CFG_WINDOW_SECONDS, 16'hFFFF);
		push_mode(mode_idle[3], mode_stall[3]);
		for (int k = 0; k < 256; k++)
			push_item(lfrl_pkg::FUNC_LOGIN, 32'h5A5A_5A5A, 32'd1000, 1'b0);
		push_item(lfrl_pkg::FUNC_QUERY, 32'h5A5A_5A5A, 32'd1000, 1'b0);
		push_item(lfrl_pkg::FUNC_LOGIN, 32'h5A5A_5A5A, 32'd1000 + 32'd65535, 1'b1);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid || want_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mism_cnt == 0 && want_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
